FILE: sv/efr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// efr_pkg - shared types and constants of the escaped frame receiver
// Framing byte codes, buffer size, result kinds, status codes, result struct
// and the escape decode table.
// ---------------------------------------------------------------------------
package efr_pkg;

    localparam int unsigned BUFFER_BYTES = 64;
    localparam int unsigned CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned POS_W        = 6;

    localparam logic [7:0] SOF_BYTE = 8'hA0;
    localparam logic [7:0] EOF_BYTE = 8'hA5;
    localparam logic [7:0] HSK_BYTE = 8'hA6;
    localparam logic [7:0] ESC_BYTE = 8'hAA;

    localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(7);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(BUFFER_BYTES);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_NO_FRAME = 3'd1,
        ST_ESC_END  = 3'd2,
        ST_BAD      = 3'd3,
        ST_SHORT    = 3'd4,
        ST_CSUM     = 3'd5
    } t_status;

    typedef struct packed {
        t_kind              result_kind;
        logic [7:0]         byte_value;
        logic [POS_W-1:0]   byte_position;
        t_status            frame_status;
        logic [7:0]         responder_addr;
        logic [5:0]         net_function;
        logic [1:0]         responder_lun;
        logic [7:0]         requester_addr;
        logic [5:0]         sequence_number;
        logic [1:0]         requester_lun;
        logic [7:0]         command_code;
        logic [5:0]         payload_length;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_unesc;

    // Map the byte after an escape to its literal value.
    function automatic t_unesc unescape(input logic [7:0] b);
        t_unesc u;
        u.ok = 1'b1;
        case (b)
            8'hB0:   u.value = SOF_BYTE;
            8'hB5:   u.value = EOF_BYTE;
            8'hB6:   u.value = HSK_BYTE;
            8'hBA:   u.value = ESC_BYTE;
            8'h3B:   u.value = 8'h1B;
            default: begin
                u.ok    = 1'b0;
                u.value = 8'h00;
            end
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: sv/efr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// efr_ifs - channel interfaces of the escaped frame receiver
// Raw byte channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface efr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] byte_value;
    logic [5:0] byte_position;
    logic [2:0] frame_status;
    logic [7:0] responder_addr;
    logic [5:0] net_function;
    logic [1:0] responder_lun;
    logic [7:0] requester_addr;
    logic [5:0] sequence_number;
    logic [1:0] requester_lun;
    logic [7:0] command_code;
    logic [5:0] payload_length;

    modport source (
        output valid, input ready,
        output result_kind, output byte_value, output byte_position,
        output frame_status, output responder_addr, output net_function,
        output responder_lun, output requester_addr, output sequence_number,
        output requester_lun, output command_code, output payload_length
    );
    modport sink (
        input valid, output ready,
        input result_kind, input byte_value, input byte_position,
        input frame_status, input responder_addr, input net_function,
        input responder_lun, input requester_addr, input sequence_number,
        input requester_lun, input command_code, input payload_length
    );
endinterface
`default_nettype wire

FILE: sv/escaped_frame_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// escaped_frame_receiver_top - byte-stuffed serial frame receiver
// Strips escaped frames from a raw byte stream and reports stored bytes,
// frame ends with status and header fields, and aborted frames.
// ---------------------------------------------------------------------------
// Usage:
//   i_rx carries one raw serial byte per item. o_res carries zero or one
//   result per raw byte: a stored frame byte with its position, a frame end
//   with status and decoded header, or an abort marker on a restart.
//   A byte taken into the input register is decoded from there; its result
//   is written into the result register, which drives o_res.
//   Throughput: one raw byte per cycle, sustained, as long as o_res is
//   drained; the decode is a few byte compares and an 8-bit add between the
//   input register and the result register.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more byte; i_rx.ready drops only when
//   both are full.
//   Reset (synchronous, active low) closes any open frame, clears the
//   escape and bad flags, the byte count and the checksum, and empties both registers.
// ---------------------------------------------------------------------------
module escaped_frame_receiver_top
    import efr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    efr_in_if.sink      i_rx,
    efr_out_if.source   o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_advance;
    logic       w_step;
    logic       w_has_result;
    t_result    w_result;

    // Decode when the result register is free or being emptied.
    assign w_advance  = !r_out_valid || o_res.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_rx.ready = !r_in_valid || w_advance;

    efr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_byte       (r_in_byte),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (w_advance) begin
                r_out_valid <= w_step && w_has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_step && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_out.result_kind;
    assign o_res.byte_value      = r_out.byte_value;
    assign o_res.byte_position   = r_out.byte_position;
    assign o_res.frame_status    = r_out.frame_status;
    assign o_res.responder_addr  = r_out.responder_addr;
    assign o_res.net_function    = r_out.net_function;
    assign o_res.responder_lun   = r_out.responder_lun;
    assign o_res.requester_addr  = r_out.requester_addr;
    assign o_res.sequence_number = r_out.sequence_number;
    assign o_res.requester_lun   = r_out.requester_lun;
    assign o_res.command_code    = r_out.command_code;
    assign o_res.payload_length  = r_out.payload_length;

    // A stop byte always produces a frame end result.
    a_eof_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_byte == EOF_BYTE) |=> (r_out_valid && r_out.result_kind == KIND_END))
        else $error("stop byte did not produce a frame end result");

    // Header fields are only reported for a good frame.
    a_hdr_good : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_status != ST_GOOD) |->
        (r_out.responder_addr == 8'h00 && r_out.command_code == 8'h00
         && r_out.payload_length == 6'd0))
        else $error("header fields set on a frame that is not good");

    // A waiting byte in the input register is not lost or overwritten.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register changed while stalled");

endmodule
`default_nettype wire

FILE: sv/efr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// efr_core - deframing state and per-byte decode
// Holds frame state, decodes one raw byte per step and presents the
// result it causes, if any.
// ---------------------------------------------------------------------------
module efr_core
    import efr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_has_result,
    output t_result         o_result
);

    logic             r_in_frame, n_in_frame;
    logic             r_esc, n_esc;
    logic             r_bad, n_bad;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_hb0, n_hb0;
    logic [7:0]       r_hb1, n_hb1;
    logic [7:0]       r_hb3, n_hb3;
    logic [7:0]       r_hb4, n_hb4;
    logic [7:0]       r_hb5, n_hb5;

    t_unesc           w_plain;
    t_status          w_status;
    logic [CNT_W-1:0] w_len;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_esc        = r_esc;
        n_bad        = r_bad;
        n_count      = r_count;
        n_sum        = r_sum;
        n_hb0        = r_hb0;
        n_hb1        = r_hb1;
        n_hb3        = r_hb3;
        n_hb4        = r_hb4;
        n_hb5        = r_hb5;
        o_has_result = 1'b0;
        o_result     = '0;
        w_len        = r_count - MIN_FRAME;

        // Literal byte, or the decoded one after an escape.
        if (r_esc) begin
            w_plain = unescape(i_byte);
        end else begin
            w_plain.ok    = 1'b1;
            w_plain.value = i_byte;
        end

        if (!r_in_frame) begin
            w_status = ST_NO_FRAME;
        end else if (r_esc) begin
            w_status = ST_ESC_END;
        end else if (r_bad) begin
            w_status = ST_BAD;
        end else if (r_count < MIN_FRAME) begin
            w_status = ST_SHORT;
        end else if (r_sum != 8'h00) begin
            w_status = ST_CSUM;
        end else begin
            w_status = ST_GOOD;
        end

        if (i_byte == SOF_BYTE) begin
            if (r_in_frame) begin
                o_has_result         = 1'b1;
                o_result.result_kind = KIND_ABORT;
            end
            n_in_frame = 1'b1;
            n_count    = '0;
            n_sum      = 8'h00;
            n_bad      = 1'b0;
            n_esc      = 1'b0;
        end else if (i_byte == EOF_BYTE) begin
            o_has_result          = 1'b1;
            o_result.result_kind  = KIND_END;
            o_result.frame_status = w_status;
            if (w_status == ST_GOOD) begin
                o_result.responder_addr  = r_hb0;
                o_result.net_function    = r_hb1[7:2];
                o_result.responder_lun   = r_hb1[1:0];
                o_result.requester_addr  = r_hb3;
                o_result.sequence_number = r_hb4[7:2];
                o_result.requester_lun   = r_hb4[1:0];
                o_result.command_code    = r_hb5;
                o_result.payload_length  = w_len[5:0];
            end
            n_in_frame = 1'b0;
            n_esc      = 1'b0;
        end else if (i_byte == HSK_BYTE) begin
            n_esc = 1'b0;
        end else if (i_byte == ESC_BYTE) begin
            if (!r_bad) begin
                n_esc = 1'b1;
            end
        end else if (r_in_frame) begin
            n_esc = 1'b0;
            if (!w_plain.ok) begin
                n_bad = 1'b1;
            end else if (!r_bad) begin
                if (r_count >= CNT_FULL) begin
                    // Buffer full: drop the byte and spoil the frame.
                    n_bad = 1'b1;
                end else begin
                    if (r_count == CNT_W'(0)) n_hb0 = w_plain.value;
                    if (r_count == CNT_W'(1)) n_hb1 = w_plain.value;
                    if (r_count == CNT_W'(3)) n_hb3 = w_plain.value;
                    if (r_count == CNT_W'(4)) n_hb4 = w_plain.value;
                    if (r_count == CNT_W'(5)) n_hb5 = w_plain.value;
                    n_sum                  = r_sum + w_plain.value;
                    n_count                = r_count + CNT_W'(1);
                    o_has_result           = 1'b1;
                    o_result.result_kind   = KIND_BYTE;
                    o_result.byte_value    = w_plain.value;
                    o_result.byte_position = r_count[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_bad      <= 1'b0;
            r_count    <= '0;
            r_sum      <= 8'h00;
            r_hb0      <= 8'h00;
            r_hb1      <= 8'h00;
            r_hb3      <= 8'h00;
            r_hb4      <= 8'h00;
            r_hb5      <= 8'h00;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_bad      <= n_bad;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_hb0      <= n_hb0;
            r_hb1      <= n_hb1;
            r_hb3      <= n_hb3;
            r_hb4      <= n_hb4;
            r_hb5      <= n_hb5;
        end
    end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - escaped frame receiver
// Streams raw serial bytes into the receiver: a short directed sequence,
// then random frames, both well formed and broken, with noise between them.
// A behavioral deframer predicts every stored byte, frame end and abort, and
// a monitor checks each result field by field. Both channels idle at random,
// and once the result side holds off long enough to back up the input.
// ---------------------------------------------------------------------------
module testbench;
    import efr_pkg::*;

    // byte after an escape and the literal it stands for
    localparam logic [7:0] ESC_OF_SOF = 8'hB0;
    localparam logic [7:0] ESC_OF_EOF = 8'hB5;
    localparam logic [7:0] ESC_OF_HSK = 8'hB6;
    localparam logic [7:0] ESC_OF_ESC = 8'hBA;
    localparam logic [7:0] ESC_OF_CTL = 8'h3B;
    localparam logic [7:0] CTL_BYTE   = 8'h1B;
    // a byte up to this is never a framing byte; only ESC_OF_CTL among them is a valid escape target
    localparam int unsigned PLAIN_TOP = 8'h9F;

    localparam int unsigned TARGET_ITEMS = 750;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    efr_in_if  rx_if ();
    efr_out_if res_if ();

    escaped_frame_receiver_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // deframer state
    bit         frame_open    = 1'b0;
    bit         esc_armed     = 1'b0;
    bit         frame_corrupt = 1'b0;
    int         byte_count    = 0;
    logic [7:0] sum_acc       = '0;
    logic [7:0] hdr_bytes [0:5] = '{default: '0};

    logic [7:0] raw_pending [$];
    t_result    expected_results [$];

    int  errors = 0;
    int  items_taken = 0;
    int  total_items = 0;
    int  bytes_seen = 0;
    int  ends_seen = 0;
    int  good_seen = 0;
    int  aborts_seen = 0;

    bit  rx_sent = 1'b0;
    int  rx_gap = 0;
    bit  rx_steady = 1'b0;
    bit  res_taken = 1'b0;
    int  res_wait = 0;
    bit  res_steady = 1'b0;
    bit  res_hold = 1'b0;

    t_result predicted;
    t_result oldest;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the deframer by one raw byte; return 1 when it yields a result.
    function automatic bit deframe(input logic [7:0] raw, output t_result r);
        logic [7:0] b;
        bit         emit;
        bit         ok;
        b    = raw;
        emit = 1'b0;
        ok   = 1'b1;
        r    = '0;
        if (raw == SOF_BYTE) begin
            emit          = frame_open;
            r.result_kind = KIND_ABORT;
            frame_open    = 1'b1;
            byte_count    = 0;
            sum_acc       = '0;
            frame_corrupt = 1'b0;
            esc_armed     = 1'b0;
        end else if (raw == EOF_BYTE) begin
            emit          = 1'b1;
            r.result_kind = KIND_END;
            if (!frame_open) begin
                r.frame_status = ST_NO_FRAME;
            end else if (esc_armed) begin
                r.frame_status = ST_ESC_END;
            end else if (frame_corrupt) begin
                r.frame_status = ST_BAD;
            end else if (byte_count < int'(MIN_FRAME)) begin
                r.frame_status = ST_SHORT;
            end else if (sum_acc != 8'd0) begin
                r.frame_status = ST_CSUM;
            end else begin
                r.frame_status    = ST_GOOD;
                r.responder_addr  = hdr_bytes[0];
                r.net_function    = hdr_bytes[1][7:2];
                r.responder_lun   = hdr_bytes[1][1:0];
                r.requester_addr  = hdr_bytes[3];
                r.sequence_number = hdr_bytes[4][7:2];
                r.requester_lun   = hdr_bytes[4][1:0];
                r.command_code    = hdr_bytes[5];
                r.payload_length  = 6'(byte_count - int'(MIN_FRAME));
            end
            frame_open = 1'b0;
            esc_armed  = 1'b0;
        end else if (raw == HSK_BYTE) begin
            esc_armed = 1'b0;
        end else if (raw == ESC_BYTE) begin
            if (!frame_corrupt) begin
                esc_armed = 1'b1;
            end
        end else if (frame_open) begin
            if (esc_armed) begin
                esc_armed = 1'b0;
                case (raw)
                    ESC_OF_SOF: b = SOF_BYTE;
                    ESC_OF_EOF: b = EOF_BYTE;
                    ESC_OF_HSK: b = HSK_BYTE;
                    ESC_OF_ESC: b = ESC_BYTE;
                    ESC_OF_CTL: b = CTL_BYTE;
                    default: begin
                        ok            = 1'b0;
                        frame_corrupt = 1'b1;
                    end
                endcase
            end
            if (ok && !frame_corrupt) begin
                if (byte_count >= int'(BUFFER_BYTES)) begin
                    frame_corrupt = 1'b1;
                end else begin
                    if (byte_count < 6) begin
                        hdr_bytes[byte_count] = b;
                    end
                    sum_acc         = sum_acc + b;
                    r.result_kind   = KIND_BYTE;
                    r.byte_value    = b;
                    r.byte_position = 6'(byte_count);
                    byte_count++;
                    emit = 1'b1;
                end
            end
        end
        return emit;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Wait for this many cycles before the next item; flip into or out of a
    // no-wait stretch now and then.
    function automatic int draw_wait(inout bit steady);
        if ($urandom_range(0, 39) == 0) begin
            steady = !steady;
        end
        return steady ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Bias content toward bytes that need stuffing.
    function automatic logic [7:0] pick_content();
        case ($urandom_range(0, 11))
            0:       return SOF_BYTE;
            1:       return EOF_BYTE;
            2:       return HSK_BYTE;
            3:       return ESC_BYTE;
            4:       return CTL_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_stuffed(input logic [7:0] b, input bit hsk_in_escape);
        if (b == SOF_BYTE || b == EOF_BYTE || b == HSK_BYTE || b == ESC_BYTE ||
            (b == CTL_BYTE && $urandom_range(0, 1) == 1)) begin
            raw_pending.push_back(ESC_BYTE);
            // a handshake here cancels the escape and the next byte goes in raw
            if (hsk_in_escape) begin
                raw_pending.push_back(HSK_BYTE);
            end
            raw_pending.push_back(b == CTL_BYTE ? ESC_OF_CTL : 8'(b + 8'h10));
        end else begin
            raw_pending.push_back(b);
        end
    endtask

    task automatic add_frame();
        logic [7:0]  body [$];
        logic [7:0]  sum;
        logic [7:0]  bad;
        int unsigned len;
        int unsigned flavor;
        int unsigned cut;
        flavor = $urandom_range(0, 15);
        case (flavor)
            0:       len = $urandom_range(0, 1) ? BUFFER_BYTES
                                                : BUFFER_BYTES + $urandom_range(1, 4);
            1:       len = $urandom_range(0, 6);
            default: len = $urandom_range(7, 20);
        endcase
        sum = '0;
        for (int unsigned i = 1; i < len; i++) begin
            body.push_back(pick_content());
            sum = sum + body[$];
        end
        if (len > 0) begin
            // close the sum to zero, or miss it on purpose
            body.push_back(8'(-sum) + (flavor == 2 ? 8'($urandom_range(1, 255)) : 8'd0));
        end
        cut = $urandom_range(0, len);

        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) raw_pending.push_back(8'($urandom_range(0, 255)));
        end
        raw_pending.push_back(SOF_BYTE);
        foreach (body[i]) begin
            if (i == cut && flavor == 3) begin
                bad = 8'($urandom_range(0, PLAIN_TOP));
                if (bad == ESC_OF_CTL) begin
                    bad = bad ^ 8'h01;
                end
                raw_pending.push_back(ESC_BYTE);
                raw_pending.push_back(bad);
                if ($urandom_range(0, 1) == 1) begin
                    raw_pending.push_back(ESC_BYTE);
                end
            end
            if (i == cut && flavor == 4) begin
                raw_pending.push_back(SOF_BYTE);
            end
            if (flavor == 6 && $urandom_range(0, 3) == 0) begin
                raw_pending.push_back(HSK_BYTE);
            end
            push_stuffed(body[i], flavor == 5 && $urandom_range(0, 2) == 0);
        end
        if (flavor == 7) begin
            raw_pending.push_back(ESC_BYTE);
        end
        if (flavor != 8) begin
            raw_pending.push_back(EOF_BYTE);
        end
    endtask

    // input side: record the accepted item and predict its result
    always @(posedge clk) begin
        if (rst_n && rx_if.valid && rx_if.ready) begin
            if (deframe(rx_if.rx_byte, predicted)) begin
                expected_results.push_back(predicted);
            end
            void'(raw_pending.pop_front());
            rx_sent = 1'b1;
            items_taken++;
        end
    end

    // input side: offer the next item after its gap
    always @(negedge clk) begin
        if (!rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_sent) begin
            rx_sent = 1'b0;
            if (rx_gap > 0) begin
                rx_gap--;
                rx_if.valid <= 1'b0;
            end else if (raw_pending.size() > 0) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= raw_pending[0];
                rx_gap = draw_wait(rx_steady);
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // result side: check each accepted result against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            res_taken = 1'b1;
            if (res_if.result_kind == KIND_BYTE) bytes_seen++;
            if (res_if.result_kind == KIND_ABORT) aborts_seen++;
            if (res_if.result_kind == KIND_END) begin
                ends_seen++;
                if (res_if.frame_status == ST_GOOD) good_seen++;
            end
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d", res_if.result_kind);
                errors++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("result_kind", 8'(oldest.result_kind), 8'(res_if.result_kind));
                check_field("byte_value", oldest.byte_value, res_if.byte_value);
                check_field("byte_position", 8'(oldest.byte_position),
                            8'(res_if.byte_position));
                check_field("frame_status", 8'(oldest.frame_status),
                            8'(res_if.frame_status));
                check_field("responder_addr", oldest.responder_addr, res_if.responder_addr);
                check_field("net_function", 8'(oldest.net_function),
                            8'(res_if.net_function));
                check_field("responder_lun", 8'(oldest.responder_lun),
                            8'(res_if.responder_lun));
                check_field("requester_addr", oldest.requester_addr, res_if.requester_addr);
                check_field("sequence_number", 8'(oldest.sequence_number),
                            8'(res_if.sequence_number));
                check_field("requester_lun", 8'(oldest.requester_lun),
                            8'(res_if.requester_lun));
                check_field("command_code", oldest.command_code, res_if.command_code);
                check_field("payload_length", 8'(oldest.payload_length),
                            8'(res_if.payload_length));
            end
        end
    end

    // result side: stall at random, and throughout the hold
    always @(negedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                res_taken = 1'b0;
                res_wait  = draw_wait(res_steady);
            end
            if (res_wait > 0) begin
                res_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !res_hold;
            end
        end
    end

    // hold off the result side while input keeps coming, so the input backs up
    initial begin
        wait (items_taken >= 250);
        @(posedge clk);
        res_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_hold = 1'b0;
    end

    initial begin
        #(2_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [7:0] directed [$];
        clk           = 1'b0;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;

        directed = '{
            // stop with no frame open
            EOF_BYTE,
            // escape outside a frame, ignored byte, stop
            ESC_BYTE, 8'h12, EOF_BYTE,
            // good frame built from every escape: A0 A5 A6 AA 1B 00 50
            SOF_BYTE, ESC_BYTE, ESC_OF_SOF, ESC_BYTE, ESC_OF_EOF, ESC_BYTE, ESC_OF_HSK,
            ESC_BYTE, ESC_OF_ESC, ESC_BYTE, ESC_OF_CTL, 8'h00, 8'h50, EOF_BYTE,
            // bad escape, then an escape that the bad frame ignores
            SOF_BYTE, 8'hFF, ESC_BYTE, 8'h77, ESC_BYTE, EOF_BYTE
        };
        foreach (directed[i]) raw_pending.push_back(directed[i]);
        while (raw_pending.size() < TARGET_ITEMS) add_frame();
        total_items = raw_pending.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (raw_pending.size() != 0 || expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d raw bytes; got %0d stored bytes, %0d aborts,", total_items,
                 bytes_seen, aborts_seen);
        $display("and %0d frame ends of which %0d were good.", ends_seen, good_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: escaped_frame_receiver_top.f
sv/efr_pkg.sv
sv/efr_ifs.sv
sv/efr_core.sv
sv/escaped_frame_receiver_top.sv
tb/testbench.sv
